[rtl/core/mma_pkg.sv]
// ---------------------------------------------------------------------------
// mma_pkg: shared types and constants of the matrix multiply-accumulate core
// Function codes, register indexes, fixed field widths and the control
// bundle passed from the sequencer to the datapath.
// ---------------------------------------------------------------------------
package mma_pkg;

   // Fixed field widths
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 6;
   localparam int ELEM_W = 32;
   localparam int ACC_W  = 64;
   localparam int CFG_W  = 7;
   localparam int REG_W  = 2;

   // Function codes of an input item
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_A  = 2'd0,
      FUNC_LOAD_B  = 2'd1,
      FUNC_LOAD_C  = 2'd2,
      FUNC_COMPUTE = 2'd3
   } func_type;

   // Configuration register indexes
   localparam logic [REG_W-1:0] REG_ROWS  = 2'd0;
   localparam logic [REG_W-1:0] REG_INNER = 2'd1;
   localparam logic [REG_W-1:0] REG_COLS  = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // Sequencer to datapath control bundle
   typedef struct packed {
      logic             idle;      // waiting for an item
      logic             acc_load;  // load accumulator from C read data
      logic             rd_issue;  // issue one A/B read pair at k
      logic [CFG_W-1:0] k;         // inner index of the read pair
      logic             finish;    // deliver the result when output is free
      logic             in_range;  // compute position lies inside the sizes
      logic [IDX_W-1:0] row;       // held row of the compute item
      logic [IDX_W-1:0] col;       // held column of the compute item
   } seq_ctrl_type;

endpackage

[rtl/core/mma_if.sv]
// ---------------------------------------------------------------------------
// mma interfaces: request, response and register write channels
// Each channel carries valid, ready and its payload; an item moves on a
// rising clock edge with valid and ready both high.
// ---------------------------------------------------------------------------
interface mma_req_if;
   import mma_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [IDX_W-1:0]         row;
   logic [IDX_W-1:0]         col;
   logic signed [ELEM_W-1:0] elem_value;

   modport source (output valid, func, row, col, elem_value, input ready);
   modport sink   (input valid, func, row, col, elem_value, output ready);
endinterface

interface mma_rsp_if;
   import mma_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] c_value;
   logic                    saturated;

   modport source (output valid, c_value, saturated, input ready);
   modport sink   (input valid, c_value, saturated, output ready);
endinterface

interface mma_csr_if;
   import mma_pkg::*;
   logic             valid;
   logic             ready;
   logic [REG_W-1:0] reg_index;
   logic [CFG_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/mma_mac.sv]
// ---------------------------------------------------------------------------
// mma_mac: shared multiply-accumulate unit
// Registers one signed 32x32 product per cycle and adds it into a Q32.32
// accumulator that clamps to the signed 64-bit range with a sticky flag.
// ---------------------------------------------------------------------------
module mma_mac
   import mma_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     acc_load,
   input  logic signed [ACC_W-1:0]  acc_init,
   input  logic                     in_valid,
   input  logic signed [ELEM_W-1:0] a_val,
   input  logic signed [ELEM_W-1:0] b_val,
   output logic                     busy,
   output logic signed [ACC_W-1:0]  acc,
   output logic                     sat
);

   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] prod_ff;
   logic                    prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic                    sat_ff;
   logic                    sat_in;
   logic [ACC_W:0]          sum;
   logic                    ovf;

   // Product of two Q16.16 values is exact Q32.32
   assign prod_in = a_val * b_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Saturating add: clamp toward the sign of the true sum
   assign sum = {acc_ff[ACC_W-1], acc_ff} + {prod_ff[ACC_W-1], prod_ff};
   assign ovf = sum[ACC_W] ^ sum[ACC_W-1];

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (acc_load) begin
         acc_in = acc_init;
         sat_in = 1'b0;
      end else if (prod_vld_ff) begin
         if (ovf) begin
            acc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            sat_in = 1'b1;
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sat_ff <= sat_in;
   end

   assign busy = prod_vld_ff;
   assign acc  = acc_ff;
   assign sat  = sat_ff;

endmodule

[rtl/core/mma_ctrl.sv]
// ---------------------------------------------------------------------------
// mma_ctrl: sequencer and size registers
// Holds the configured sizes, checks a compute position against them and
// steps the inner index through the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
module mma_ctrl
   import mma_pkg::*;
#(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_INNER = 64,
   parameter int MAX_COLS  = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic              csr_fire,
   input  logic [REG_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              mac_busy,
   input  logic              rsp_free,
   output seq_ctrl_type      ctrl
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_START  = 5'b00010,
      ST_RUN    = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [CFG_W-1:0] nr, ni, nc;
   logic [CFG_W-1:0] ni_ff, ni_in;
   logic [CFG_W-1:0] k_ff, k_in;
   logic             in_range_ff, in_range_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic             pos_ok;

   // Register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= CFG_RESET;
         inner_ff <= CFG_RESET;
         cols_ff  <= CFG_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            REG_ROWS:  rows_ff  <= csr_wdata;
            REG_INNER: inner_ff <= csr_wdata;
            REG_COLS:  cols_ff  <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // Effective sizes: register clipped to the store size
   assign nr = (32'(rows_ff)  < MAX_ROWS)  ? rows_ff  : CFG_W'(MAX_ROWS);
   assign ni = (32'(inner_ff) < MAX_INNER) ? inner_ff : CFG_W'(MAX_INNER);
   assign nc = (32'(cols_ff)  < MAX_COLS)  ? cols_ff  : CFG_W'(MAX_COLS);

   assign pos_ok = ({1'b0, req_row} < nr) && ({1'b0, req_col} < nc);

   // Sequence one compute item
   always_comb begin
      state_in    = state_ff;
      ni_in       = ni_ff;
      k_in        = k_ff;
      in_range_in = in_range_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == FUNC_COMPUTE)) begin
               row_in      = req_row;
               col_in      = req_col;
               ni_in       = ni;
               k_in        = '0;
               in_range_in = pos_ok;
               state_in    = pos_ok ? ST_START : ST_FINISH;
            end
         end
         ST_START: begin
            state_in = (ni_ff != '0) ? ST_RUN : ST_DRAIN;
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            if (k_ff == ni_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ni_ff       <= ni_in;
      k_ff        <= k_in;
      in_range_ff <= in_range_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
   end

   assign ctrl.idle     = (state_ff == ST_IDLE);
   assign ctrl.acc_load = (state_ff == ST_START);
   assign ctrl.rd_issue = (state_ff == ST_RUN);
   assign ctrl.k        = k_ff;
   assign ctrl.finish   = (state_ff == ST_FINISH);
   assign ctrl.in_range = in_range_ff;
   assign ctrl.row      = row_ff;
   assign ctrl.col      = col_ff;

endmodule

[rtl/core/matrix_multiply_accumulate_core.sv]
// ---------------------------------------------------------------------------
// matrix_multiply_accumulate_core: C += A x B one output element at a time
// Element stores for A, B and C around one shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries items: func selects load A, load B, load C or compute.
//   Loads write one Q16.16 element (C widened to Q32.32) and return nothing;
//   a load outside the store is dropped. A compute item names (row, col) and
//   returns the new C element and a saturated flag on rsp_bus.
//   csr_bus writes rows_in_use, inner_size and cols_in_use; write it only
//   while the core is idle.
// Sequence:
//   A load is written into its store as it is taken. A compute item loads
//   the accumulator from C, then steps k through the single A/B read port
//   pair feeding one multiply per cycle, drains the multiplier and registers
//   its result; an out-of-range compute goes straight to its result.
//   req_bus.ready is low from the accept until the result appears.
// Reset: sizes return to 64; the stores hold no defined data until loaded.
// Stall: the result waits in the output register while rsp_bus.ready is low;
//   loads are still taken, and a following compute holds before its result.
// ---------------------------------------------------------------------------
module matrix_multiply_accumulate_core
   import mma_pkg::*;
#(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_INNER = 64,
   parameter int MAX_COLS  = 64
)
(
   input  logic      clock,
   input  logic      reset,
   mma_req_if.sink   req_bus,
   mma_rsp_if.source rsp_bus,
   mma_csr_if.sink   csr_bus
);

   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

   seq_ctrl_type            ctrl;
   logic                    req_fire;
   logic                    csr_fire;
   logic                    rsp_free;
   logic                    mac_busy;
   logic                    mac_prod_busy;
   logic signed [ACC_W-1:0] mac_acc;
   logic                    mac_sat;

   logic signed [ELEM_W-1:0] a_mem [A_DEPTH];
   logic signed [ELEM_W-1:0] b_mem [B_DEPTH];
   logic signed [ACC_W-1:0]  c_mem [C_DEPTH];

   logic [A_AW-1:0]          a_waddr, a_raddr;
   logic [B_AW-1:0]          b_waddr, b_raddr;
   logic [C_AW-1:0]          c_waddr, c_raddr, c_load_addr, c_pos_addr;
   logic                     a_we, b_we, c_we;
   logic signed [ACC_W-1:0]  c_wdata;
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic signed [ACC_W-1:0]  c_rd_ff;
   logic                     rd_vld_ff;

   logic                    rsp_valid_ff;
   logic signed [ACC_W-1:0] rsp_value_ff;
   logic                    rsp_sat_ff;
   logic                    rsp_load;

   assign req_bus.ready = ctrl.idle;
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign csr_fire      = csr_bus.valid & csr_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   mma_ctrl #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_func  (req_bus.func),
      .req_row   (req_bus.row),
      .req_col   (req_bus.col),
      .csr_fire  (csr_fire),
      .csr_index (csr_bus.reg_index),
      .csr_wdata (csr_bus.wdata),
      .mac_busy  (mac_busy),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl)
   );

   // Load addresses and enables, dropped outside the store
   assign a_waddr = A_AW'(32'(req_bus.row) * MAX_INNER + 32'(req_bus.col));
   assign b_waddr = B_AW'(32'(req_bus.row) * MAX_COLS + 32'(req_bus.col));
   assign c_load_addr = C_AW'(32'(req_bus.row) * MAX_COLS + 32'(req_bus.col));

   assign a_we = req_fire && (req_bus.func == FUNC_LOAD_A)
                 && (32'(req_bus.row) < MAX_ROWS) && (32'(req_bus.col) < MAX_INNER);
   assign b_we = req_fire && (req_bus.func == FUNC_LOAD_B)
                 && (32'(req_bus.row) < MAX_INNER) && (32'(req_bus.col) < MAX_COLS);

   // Compute addresses from the held position and inner index
   assign a_raddr    = A_AW'(32'(ctrl.row) * MAX_INNER + 32'(ctrl.k));
   assign b_raddr    = B_AW'(32'(ctrl.k) * MAX_COLS + 32'(ctrl.col));
   assign c_pos_addr = C_AW'(32'(ctrl.row) * MAX_COLS + 32'(ctrl.col));
   assign c_raddr    = ctrl.idle ? c_load_addr : c_pos_addr;

   // C takes loads when idle and the new sum when an in-range compute item finishes
   assign rsp_load = ctrl.finish && rsp_free;
   always_comb begin
      c_we    = 1'b0;
      c_waddr = c_load_addr;
      c_wdata = {{(ACC_W-ELEM_W-16){req_bus.elem_value[ELEM_W-1]}},
                 req_bus.elem_value, 16'b0};
      if (rsp_load) begin
         c_we    = ctrl.in_range;
         c_waddr = c_pos_addr;
         c_wdata = mac_acc;
      end else if (req_fire && (req_bus.func == FUNC_LOAD_C)
                   && (32'(req_bus.row) < MAX_ROWS) && (32'(req_bus.col) < MAX_COLS)) begin
         c_we = 1'b1;
      end
   end

   // Element stores
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[a_waddr] <= req_bus.elem_value;
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[b_waddr] <= req_bus.elem_value;
      end
      b_rd_ff <= b_mem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem[c_waddr] <= c_wdata;
      end
      c_rd_ff <= c_mem[c_raddr];
   end

   // Mark read pairs on their way to the multiplier
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.rd_issue;
      end
   end

   mma_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .acc_load (ctrl.acc_load),
      .acc_init (c_rd_ff),
      .in_valid (rd_vld_ff),
      .a_val    (a_rd_ff),
      .b_val    (b_rd_ff),
      .busy     (mac_prod_busy),
      .acc      (mac_acc),
      .sat      (mac_sat)
   );

   assign mac_busy = rd_vld_ff | mac_prod_busy;

   // Output register: hold the item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= ctrl.in_range ? mac_acc : '0;
         rsp_sat_ff   <= ctrl.in_range ? mac_sat : 1'b1;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.c_value   = rsp_value_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

endmodule
